// ===== sv/fac_pkg.sv =====
package fac_pkg;

  // Fixed widths of the ports and of the configuration registers.
  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned REG_WIDTH   = 64;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned NUM_PLANES  = 6;

  // Number format of the box coordinates.
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  // A plane component is the exact sum or difference of two matrix entries.
  localparam int unsigned NORM_WIDTH = ENTRY_WIDTH + 1;
  localparam int unsigned PROD_WIDTH = NORM_WIDTH + COORD_WIDTH;
  localparam int unsigned DSH_WIDTH  = NORM_WIDTH + FRAC_BITS;
  localparam int unsigned SUM_WIDTH  =
      ((PROD_WIDTH > DSH_WIDTH) ? PROD_WIDTH : DSH_WIDTH) + 2;

  // Register stages from the accepting edge to the result strobe.
  localparam int unsigned LATENCY = 5;

  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef logic signed [NORM_WIDTH-1:0]  norm_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  typedef struct packed {
    norm_t nx;
    norm_t ny;
    norm_t nz;
    norm_t d;
  } plane_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

endpackage

// ===== sv/frustum_aabb_cull_test.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// box in   | start_i, busy_o      | box_min_x_i .. box_max_z_i, 32 bits signed
// result   | done_o (one cycle)   | visible_o
// config   | cfg_we_i             | cfg_idx_i (0..7), cfg_data_i (64 bits)
//
// One box word is taken every cycle; busy_o stays low. The verdict is on done_o
// once the word has passed the box input, corner select, multiplier, adder and
// verdict register stages.
// Reset clears the matrix to zero and drops every word in flight.
// The receiver cannot stall; results leave in order, one per box.
module frustum_aabb_cull_test (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_min_x_i,
  input  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_min_y_i,
  input  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_min_z_i,
  input  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_max_x_i,
  input  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_max_y_i,
  input  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_max_z_i,
  output logic                                  done_o,
  output logic                                  visible_o,
  input  logic                                  cfg_we_i,
  input  logic [fac_pkg::REG_IDX_W-1:0]         cfg_idx_i,
  input  logic [fac_pkg::REG_WIDTH-1:0]         cfg_data_i
);

  fac_pkg::plane_t              plane [fac_pkg::NUM_PLANES];
  fac_pkg::box_t                box_d, box_q;
  logic [fac_pkg::LATENCY-1:0]  valid_q;
  logic [fac_pkg::NUM_PLANES-1:0] reject;
  logic                         visible_q;
  logic                         accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  fac_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .plane_o    (plane)
  );

  // Bits above the coordinate width are ignored.
  always_comb begin
    box_d.min_x = box_min_x_i[fac_pkg::COORD_WIDTH-1:0];
    box_d.min_y = box_min_y_i[fac_pkg::COORD_WIDTH-1:0];
    box_d.min_z = box_min_z_i[fac_pkg::COORD_WIDTH-1:0];
    box_d.max_x = box_max_x_i[fac_pkg::COORD_WIDTH-1:0];
    box_d.max_y = box_max_y_i[fac_pkg::COORD_WIDTH-1:0];
    box_d.max_z = box_max_z_i[fac_pkg::COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  for (genvar p = 0; p < fac_pkg::NUM_PLANES; p++) begin : g_lane
    fac_plane_test u_plane (
      .clk_i    (clk_i),
      .box_i    (box_q),
      .plane_i  (plane[p]),
      .reject_o (reject[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[fac_pkg::LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= ~(|reject);
  end

  assign done_o    = valid_q[fac_pkg::LATENCY-1];
  assign visible_o = visible_q;

endmodule

// ===== sv/fac_cfg.sv =====
module fac_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fac_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fac_pkg::REG_WIDTH-1:0]        cfg_data_i,
  output fac_pkg::plane_t                      plane_o [fac_pkg::NUM_PLANES]
);

  logic [fac_pkg::REG_WIDTH-1:0] regs_q [fac_pkg::NUM_REGS];
  fac_pkg::entry_t               ent [4][4];
  fac_pkg::plane_t               plane_d [fac_pkg::NUM_PLANES];
  fac_pkg::plane_t               plane_q [fac_pkg::NUM_PLANES];

  function automatic fac_pkg::norm_t combine(fac_pkg::entry_t a, fac_pkg::entry_t b,
                                             logic minus);
    fac_pkg::norm_t ea;
    fac_pkg::norm_t eb;
    ea = fac_pkg::norm_t'(a);
    eb = fac_pkg::norm_t'(b);
    return minus ? (ea - eb) : (ea + eb);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fac_pkg::NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Register 2c holds rows 0 and 1 of column c, register 2c+1 rows 2 and 3.
  for (genvar c = 0; c < 4; c++) begin : g_col
    assign ent[0][c] = regs_q[2*c][fac_pkg::ENTRY_WIDTH-1:0];
    assign ent[1][c] = regs_q[2*c][fac_pkg::REG_WIDTH-1:fac_pkg::ENTRY_WIDTH];
    assign ent[2][c] = regs_q[2*c+1][fac_pkg::ENTRY_WIDTH-1:0];
    assign ent[3][c] = regs_q[2*c+1][fac_pkg::REG_WIDTH-1:fac_pkg::ENTRY_WIDTH];
  end

  // Planes come in pairs per axis: row 3 plus the axis row, then row 3 minus it.
  for (genvar p = 0; p < fac_pkg::NUM_PLANES; p++) begin : g_plane
    localparam int Axis = p / 2;
    localparam logic Minus = logic'(p % 2);
    assign plane_d[p].nx = combine(ent[3][0], ent[Axis][0], Minus);
    assign plane_d[p].ny = combine(ent[3][1], ent[Axis][1], Minus);
    assign plane_d[p].nz = combine(ent[3][2], ent[Axis][2], Minus);
    assign plane_d[p].d  = combine(ent[3][3], ent[Axis][3], Minus);

    always_ff @(posedge clk_i) begin
      plane_q[p] <= plane_d[p];
    end

    assign plane_o[p] = plane_q[p];
  end

endmodule

// ===== sv/fac_plane_test.sv =====
module fac_plane_test (
  input  logic            clk_i,
  input  fac_pkg::box_t   box_i,
  input  fac_pkg::plane_t plane_i,
  output logic            reject_o
);

  fac_pkg::coord_t cx_d, cy_d, cz_d;
  fac_pkg::coord_t cx_q, cy_q, cz_q;
  fac_pkg::norm_t  nx_q, ny_q, nz_q, d1_q, d2_q;
  logic            live_d, live1_q, live2_q, live3_q;
  fac_pkg::prod_t  px_q, py_q, pz_q;
  fac_pkg::sum_t   suma_q, sumb_q, dsh;
  fac_pkg::sum_t   total;

  // Positive-vertex choice: the corner farthest along the normal.
  always_comb begin
    cx_d   = ($signed(plane_i.nx) > 0) ? box_i.max_x : box_i.min_x;
    cy_d   = ($signed(plane_i.ny) > 0) ? box_i.max_y : box_i.min_y;
    cz_d   = ($signed(plane_i.nz) > 0) ? box_i.max_z : box_i.min_z;
    live_d = (|plane_i.nx) | (|plane_i.ny) | (|plane_i.nz);
  end

  always_ff @(posedge clk_i) begin
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    nx_q    <= plane_i.nx;
    ny_q    <= plane_i.ny;
    nz_q    <= plane_i.nz;
    d1_q    <= plane_i.d;
    live1_q <= live_d;
  end

  always_ff @(posedge clk_i) begin
    px_q    <= fac_pkg::prod_t'(nx_q) * fac_pkg::prod_t'(cx_q);
    py_q    <= fac_pkg::prod_t'(ny_q) * fac_pkg::prod_t'(cy_q);
    pz_q    <= fac_pkg::prod_t'(nz_q) * fac_pkg::prod_t'(cz_q);
    d2_q    <= d1_q;
    live2_q <= live1_q;
  end

  // The offset d is scaled into the product's fixed-point format.
  assign dsh = fac_pkg::sum_t'(d2_q) <<< fac_pkg::FRAC_BITS;

  always_ff @(posedge clk_i) begin
    suma_q  <= fac_pkg::sum_t'(px_q) + fac_pkg::sum_t'(py_q);
    sumb_q  <= fac_pkg::sum_t'(pz_q) + dsh;
    live3_q <= live2_q;
  end

  // A plane with an all-zero normal never rejects.
  assign total    = suma_q + sumb_q;
  assign reject_o = live3_q & total[fac_pkg::SUM_WIDTH-1];

endmodule

// ===== sv/fac_checker.sv =====
module fac_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // Every accepted word yields its verdict after the fixed latency.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o) |-> ##5 done_o)
    else $error("accepted box word produced no result");

  // No result appears without a word accepted the fixed latency earlier.
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(start_i && !busy_o, 5))
    else $error("result strobe without a matching accepted word");

  // Leaving reset, nothing in flight can be reported.
  a_no_result_after_reset: assert property (@(posedge clk_i)
      $past(!rst_ni) |-> !done_o)
    else $error("result strobe right after reset");

endmodule

bind frustum_aabb_cull_test fac_checker u_fac_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned RAND_PHASES = 9;
  localparam int unsigned PHASE_BOXES = 95;

  localparam fac_pkg::coord_t Q_HALF  = 32'sh0000_8000;
  localparam fac_pkg::coord_t Q_ONE   = 32'sh0001_0000;
  localparam fac_pkg::coord_t Q_TWO   = 32'sh0002_0000;
  localparam fac_pkg::coord_t Q_THREE = 32'sh0003_0000;
  localparam fac_pkg::coord_t C_MAX   = 32'sh7FFF_FFFF;
  localparam fac_pkg::coord_t C_MIN   = 32'sh8000_0000;

  typedef enum logic [2:0] {
    MAT_ZERO,
    MAT_IDENT,
    MAT_POS_MAX,
    MAT_NEG_MAX,
    MAT_MIXED,
    MAT_VIEW,
    MAT_RANDOM_BITS
  } mat_style_e;

  typedef struct packed {
    mat_style_e    style;
    fac_pkg::box_t box;
    logic          known;
    logic          want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_min_x_i, box_min_y_i, box_min_z_i;
  logic signed [fac_pkg::FIELD_WIDTH-1:0] box_max_x_i, box_max_y_i, box_max_z_i;
  logic done_o;
  logic visible_o;
  logic cfg_we_i;
  logic [fac_pkg::REG_IDX_W-1:0] cfg_idx_i;
  logic [fac_pkg::REG_WIDTH-1:0] cfg_data_i;

  // Typed-in verdict that travels with a directed word.
  logic dir_known;
  logic dir_want;

  fac_pkg::box_t port_box;
  assign port_box = {box_min_x_i, box_min_y_i, box_min_z_i,
                     box_max_x_i, box_max_y_i, box_max_z_i};

  logic [fac_pkg::REG_WIDTH-1:0] matrix_regs [0:fac_pkg::NUM_REGS-1];
  logic [31:0]                   next_mat [0:3][0:3];
  logic                          verdict_q [$];
  dir_row_t                      dir_rows [$];

  int unsigned cycle_cnt = 0;
  int unsigned box_cnt   = 0;
  int unsigned result_cnt = 0;
  int unsigned vis_cnt   = 0;
  int unsigned cull_cnt  = 0;
  int unsigned mat_cnt   = 0;
  int unsigned fail_cnt  = 0;

  frustum_aabb_cull_test u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .box_min_x_i (box_min_x_i),
    .box_min_y_i (box_min_y_i),
    .box_min_z_i (box_min_z_i),
    .box_max_x_i (box_max_x_i),
    .box_max_y_i (box_max_y_i),
    .box_max_z_i (box_max_z_i),
    .done_o      (done_o),
    .visible_o   (visible_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts still pending.",
               cycle_cnt, verdict_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] matrix_entry(int row, int col);
    logic [fac_pkg::REG_WIDTH-1:0] w;
    w = matrix_regs[col * 2 + row / 2];
    return (row % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  // Exact plane test at full width: n.corner + d * 2^FRAC_BITS < 0 culls.
  function automatic logic box_visible(fac_pkg::box_t b);
    logic signed [95:0] lo [0:2];
    logic signed [95:0] hi [0:2];
    logic signed [95:0] nrm [0:2];
    logic signed [95:0] ent_a, ent_w, offs, total;
    logic vis;
    logic minus;
    int p, i, axis;
    lo[0] = $signed(b.min_x);
    lo[1] = $signed(b.min_y);
    lo[2] = $signed(b.min_z);
    hi[0] = $signed(b.max_x);
    hi[1] = $signed(b.max_y);
    hi[2] = $signed(b.max_z);
    vis = 1'b1;
    for (p = 0; p < fac_pkg::NUM_PLANES; p++) begin
      axis  = p / 2;
      minus = (p % 2 == 1);
      for (i = 0; i < 3; i++) begin
        ent_a  = matrix_entry(axis, i);
        ent_w  = matrix_entry(3, i);
        nrm[i] = minus ? ent_w - ent_a : ent_w + ent_a;
      end
      ent_a = matrix_entry(axis, 3);
      ent_w = matrix_entry(3, 3);
      offs  = minus ? ent_w - ent_a : ent_w + ent_a;
      // A plane with no normal never rejects anything.
      if (nrm[0] != 0 || nrm[1] != 0 || nrm[2] != 0) begin
        total = offs <<< fac_pkg::FRAC_BITS;
        for (i = 0; i < 3; i++)
          total = total + nrm[i] * ((nrm[i] > 0) ? hi[i] : lo[i]);
        if (total < 0)
          vis = 1'b0;
      end
    end
    return vis;
  endfunction

  // Predict at acceptance, check the strobe, and mirror register writes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        verdict_q.push_back(dir_known ? dir_want : box_visible(port_box));
        box_cnt++;
      end
      if (done_o) begin
        result_cnt++;
        if (visible_o === 1'b1)
          vis_cnt++;
        else
          cull_cnt++;
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("Result word %0d arrived with nothing pending (visible=%0b).",
                     result_cnt, visible_o);
        end else begin
          logic want;
          want = verdict_q.pop_front();
          if (visible_o !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN)
              $display("Mismatch on result word %0d: visible expected %0b, got %0b.",
                       result_cnt, want, visible_o);
          end
        end
      end
      if (cfg_we_i)
        matrix_regs[cfg_idx_i] = cfg_data_i;
    end
  end

  function automatic fac_pkg::box_t mk_box(fac_pkg::coord_t mnx, fac_pkg::coord_t mny,
                                           fac_pkg::coord_t mnz, fac_pkg::coord_t mxx,
                                           fac_pkg::coord_t mxy, fac_pkg::coord_t mxz);
    return {mnx, mny, mnz, mxx, mxy, mxz};
  endfunction

  task automatic add_row(mat_style_e s, fac_pkg::box_t b, logic known, logic want);
    dir_row_t r;
    r.style = s;
    r.box   = b;
    r.known = known;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic int pick_gap(bit steady);
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 98)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 40);
  endfunction

  // Mostly small boxes around the origin, the rest noise, inverted and edge values.
  function automatic fac_pkg::box_t random_box();
    logic [31:0] lo [0:2];
    logic [31:0] hi [0:2];
    logic [31:0] c, h;
    int kind, i;
    kind = $urandom_range(0, 99);
    for (i = 0; i < 3; i++) begin
      c = $urandom_range(0, 12 * 65536) - 6 * 65536;
      h = $urandom_range(0, 3 * 65536);
      if (kind < 70) begin
        lo[i] = c - h;
        hi[i] = c + h;
      end else if (kind < 85) begin
        lo[i] = $urandom;
        hi[i] = $urandom;
      end else if (kind < 95) begin
        lo[i] = c + h + 1;
        hi[i] = c - h;
      end else begin
        case ($urandom_range(0, 3))
          0:       lo[i] = C_MIN;
          1:       lo[i] = C_MAX;
          2:       lo[i] = '0;
          default: lo[i] = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0:       hi[i] = C_MIN;
          1:       hi[i] = C_MAX;
          2:       hi[i] = '0;
          default: hi[i] = $urandom;
        endcase
      end
    end
    return {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  task automatic build_matrix(mat_style_e style);
    int r, c, k;
    logic [31:0] mag;
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        next_mat[r][c] = '0;
    case (style)
      MAT_IDENT: begin
        for (k = 0; k < 4; k++)
          next_mat[k][k] = Q_ONE;
      end
      MAT_POS_MAX: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            next_mat[r][c] = C_MAX;
      end
      MAT_NEG_MAX: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            next_mat[r][c] = C_MIN;
      end
      MAT_MIXED: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            next_mat[r][c] = (r == 3) ? C_MAX : C_MIN;
      end
      MAT_RANDOM_BITS: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            next_mat[r][c] = $urandom;
      end
      MAT_VIEW: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            next_mat[r][c] = $urandom_range(0, 32768) - 16384;
        for (k = 0; k < 3; k++) begin
          mag = $urandom_range(16384, 4 * 65536);
          next_mat[k][k] = $urandom_range(0, 1) ? mag : -mag;
          next_mat[k][3] = $urandom_range(0, 4 * 65536) - 2 * 65536;
        end
        next_mat[3][3] = $urandom_range(65536, 4 * 65536);
        // Now and then one row matches row 3 or its negation so that one plane loses its normal.
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, 2);
          mag = $urandom_range(0, 1);
          for (c = 0; c < 3; c++)
            next_mat[k][c] = mag[0] ? -next_mat[3][c] : next_mat[3][c];
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_matrix();
    int idx, c;
    for (idx = 0; idx < fac_pkg::NUM_REGS; idx++) begin
      c = idx / 2;
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[fac_pkg::REG_IDX_W-1:0];
      cfg_data_i <= (idx % 2 == 0) ? {next_mat[1][c], next_mat[0][c]}
                                   : {next_mat[3][c], next_mat[2][c]};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    mat_cnt++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (fac_pkg::LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic send_box(fac_pkg::box_t b, logic known, logic want, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    box_min_x_i <= b.min_x;
    box_min_y_i <= b.min_y;
    box_min_z_i <= b.min_z;
    box_max_x_i <= b.max_x;
    box_max_y_i <= b.max_y;
    box_max_z_i <= b.max_z;
    dir_known   <= known;
    dir_want    <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    mat_style_e cur_style;
    dir_row_t   row;
    bit         steady;
    int         i, ph, n;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    box_min_x_i <= '0;
    box_min_y_i <= '0;
    box_min_z_i <= '0;
    box_max_x_i <= '0;
    box_max_y_i <= '0;
    box_max_z_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    dir_known   <= 1'b0;
    dir_want    <= 1'b0;
    for (i = 0; i < fac_pkg::NUM_REGS; i++)
      matrix_regs[i] = '0;

    // After reset every plane has a zero normal, so nothing is culled.
    add_row(MAT_ZERO, mk_box('0, '0, '0, '0, '0, '0), 1'b1, 1'b1);
    add_row(MAT_ZERO, mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1, 1'b1);
    add_row(MAT_ZERO, mk_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1'b1, 1'b1);
    // Identity matrix: the frustum is the cube from -1 to 1 on every axis.
    add_row(MAT_IDENT, mk_box(-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF),
            1'b1, 1'b1);
    add_row(MAT_IDENT, mk_box(Q_TWO, -Q_HALF, -Q_HALF, Q_THREE, Q_HALF, Q_HALF),
            1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(-Q_THREE, -Q_HALF, -Q_HALF, -Q_TWO, Q_HALF, Q_HALF),
            1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(-Q_HALF, Q_TWO, -Q_HALF, Q_HALF, Q_THREE, Q_HALF),
            1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(-Q_HALF, -Q_THREE, -Q_HALF, Q_HALF, -Q_TWO, Q_HALF),
            1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(-Q_HALF, -Q_HALF, Q_TWO, Q_HALF, Q_HALF, Q_THREE),
            1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(-Q_HALF, -Q_HALF, -Q_THREE, Q_HALF, Q_HALF, -Q_TWO),
            1'b1, 1'b0);
    // Touching a plane exactly is still visible; one step past it is not.
    add_row(MAT_IDENT, mk_box(Q_ONE, -Q_HALF, -Q_HALF, Q_TWO, Q_HALF, Q_HALF),
            1'b1, 1'b1);
    add_row(MAT_IDENT, mk_box(-Q_TWO, -Q_HALF, -Q_HALF, -Q_ONE, Q_HALF, Q_HALF),
            1'b1, 1'b1);
    add_row(MAT_IDENT, mk_box(Q_ONE + 1, -Q_HALF, -Q_HALF, Q_TWO, Q_HALF, Q_HALF),
            1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1, 1'b1);
    add_row(MAT_IDENT, mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b1, 1'b0);
    add_row(MAT_IDENT, mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b1, 1'b0);
    // Inverted boxes are taken corner by corner as given.
    add_row(MAT_IDENT, mk_box(Q_HALF, Q_HALF, Q_HALF, -Q_HALF, -Q_HALF, -Q_HALF),
            1'b1, 1'b1);
    add_row(MAT_IDENT, mk_box(Q_THREE, Q_THREE, Q_THREE, -Q_THREE, -Q_THREE, -Q_THREE),
            1'b1, 1'b0);
    // Extreme matrix entries: the verdict comes from the predictor.
    add_row(MAT_POS_MAX, mk_box('0, '0, '0, '0, '0, '0), 1'b0, 1'b0);
    add_row(MAT_POS_MAX, mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b0, 1'b0);
    add_row(MAT_POS_MAX, mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b0, 1'b0);
    add_row(MAT_NEG_MAX, mk_box('0, '0, '0, '0, '0, '0), 1'b0, 1'b0);
    add_row(MAT_NEG_MAX, mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b0, 1'b0);
    add_row(MAT_MIXED, mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b0, 1'b0);
    add_row(MAT_MIXED, mk_box(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN), 1'b0, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_style = MAT_ZERO;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.style != cur_style) begin
        wait_drained();
        build_matrix(row.style);
        write_matrix();
        cur_style = row.style;
      end
      send_box(row.box, row.known, row.want, pick_gap(1'b0));
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      build_matrix((ph % 3 == 2) ? MAT_RANDOM_BITS : MAT_VIEW);
      write_matrix();
      steady = (ph % 4 == 1);
      for (n = 0; n < PHASE_BOXES; n++)
        send_box(random_box(), 1'b0, 1'b0, pick_gap(steady));
    end

    wait_drained();
    fail_cnt += verdict_q.size();

    $display("Ran %0d box words under %0d matrix settings in %0d cycles.",
             box_cnt, mat_cnt, cycle_cnt);
    $display("Got %0d verdicts: %0d visible, %0d culled, %0d failures.",
             result_cnt, vis_cnt, cull_cnt, fail_cnt);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fac_pkg.sv
sv/fac_cfg.sv
sv/fac_plane_test.sv
sv/frustum_aabb_cull_test.sv
sv/fac_checker.sv
tb/sv/tb_top.sv
